### hdl/mtxown_pkg.sv
// Shared types and register indexes for the matrix element owner block.
`default_nettype none
package mtxown_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_ROW_CHUNK = 3'd1;
    localparam logic [2:0] REG_COL_CHUNK = 3'd2;
    localparam logic [2:0] REG_GRID_ROWS = 3'd3;
    localparam logic [2:0] REG_GRID_COLS = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FIELD_W    = 32;
    localparam int RANK_W     = 16;
    localparam int GRIDCFG_W  = 9;

    // Mode bits: bit 0 makes rows cyclic, bit 1 makes columns cyclic
    localparam int MODE_ROW_CYC = 0;
    localparam int MODE_COL_CYC = 1;

    typedef struct packed {
        logic [FIELD_W-1:0] global_row;
        logic [FIELD_W-1:0] global_col;
    } in_item_t;

    typedef struct packed {
        logic [RANK_W-1:0]  owner_rank;
        logic [FIELD_W-1:0] local_row;
        logic [FIELD_W-1:0] local_col;
        logic               out_of_grid;
    } out_item_t;

endpackage
`default_nettype wire

### hdl/matrix_element_owner_2d_unit.sv
// Top level: owner rank and local indices of a matrix element on a 2D grid.
//
//   port group   dir  handshake          payload
//   s_*          in   s_valid/s_ready    in_item_t  (global_row, global_col)
//   m_*          out  m_valid/m_ready    out_item_t (rank, local row/col, flag)
//   cfg_*        in   cfg_valid/ready    cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; the depth is set by the
// two chained bit-per-stage dividers (index by chunk, quotient by grid size).
// aresetn clears all valid bits and restores the register defaults.
// A stalled output register freezes the whole pipeline; nothing is dropped.
// Configuration writes are always taken.
`default_nettype none
module matrix_element_owner_2d_unit #(
    parameter int INDEX_BITS = 32,
    parameter int GRID_BITS  = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire mtxown_pkg::in_item_t          s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output mtxown_pkg::out_item_t              m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mtxown_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mtxown_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mtxown_pkg::*;

    localparam int IW = INDEX_BITS;
    localparam int GB = GRID_BITS;
    localparam int GW = GB + 1;

    // Configuration registers
    logic [1:0]           mode_reg;
    logic [FIELD_W-1:0]   row_chunk_reg;
    logic [FIELD_W-1:0]   col_chunk_reg;
    logic [GRIDCFG_W-1:0] grid_rows_reg;
    logic [GRIDCFG_W-1:0] grid_cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= '0;
            row_chunk_reg <= FIELD_W'(1);
            col_chunk_reg <= FIELD_W'(1);
            grid_rows_reg <= GRIDCFG_W'(1);
            grid_cols_reg <= GRIDCFG_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[1:0];
                REG_ROW_CHUNK: row_chunk_reg <= cfg_data;
                REG_COL_CHUNK: col_chunk_reg <= cfg_data;
                REG_GRID_ROWS: grid_rows_reg <= cfg_data[GRIDCFG_W-1:0];
                REG_GRID_COLS: grid_cols_reg <= cfg_data[GRIDCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective chunk and grid sizes
    function automatic logic [GW-1:0] eff_grid(input logic [GRIDCFG_W-1:0] g);
        logic [16:0] gw;
        logic [16:0] gmax;
        gw   = 17'(g);
        gmax = 17'(1) << GB;
        if (gw == '0)      return GW'(1);
        else if (gw > gmax) return gmax[GW-1:0];
        else               return gw[GW-1:0];
    endfunction

    function automatic logic [IW-1:0] eff_chunk(input logic [FIELD_W-1:0] c);
        logic [IW-1:0] cm;
        cm = IW'(c);
        return (cm == '0) ? IW'(1) : cm;
    endfunction

    logic [GW-1:0] gr_eff;
    logic [GW-1:0] gc_eff;
    assign gr_eff = eff_grid(grid_rows_reg);
    assign gc_eff = eff_grid(grid_cols_reg);

    // Pipeline advance: the output register is empty or being drained
    logic out_vld_reg;
    logic en;
    assign en      = !out_vld_reg || m_ready;
    assign s_ready = en;

    logic          r_valid, c_valid;
    logic [GB-1:0] r_coord, c_coord;
    logic [IW-1:0] r_local, c_local;
    logic          r_off, c_off;

    mtxown_dim #(.IW(IW), .GB(GB)) u_row (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .idx(IW'(s_data.global_row)),
        .chunk(eff_chunk(row_chunk_reg)), .grid(gr_eff),
        .cyclic(mode_reg[MODE_ROW_CYC]),
        .out_valid(r_valid), .coord(r_coord), .local_idx(r_local), .off(r_off)
    );

    mtxown_dim #(.IW(IW), .GB(GB)) u_col (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid), .idx(IW'(s_data.global_col)),
        .chunk(eff_chunk(col_chunk_reg)), .grid(gc_eff),
        .cyclic(mode_reg[MODE_COL_CYC]),
        .out_valid(c_valid), .coord(c_coord), .local_idx(c_local), .off(c_off)
    );

    // Rank and output register
    logic [2*GB+1:0] rank_full;
    logic [31:0]     rank_ext;
    logic            off_any;
    out_item_t       out_reg;

    assign off_any   = r_off || c_off;
    assign rank_full = (2*GB+2)'(r_coord) * (2*GB+2)'(gc_eff) + (2*GB+2)'(c_coord);
    assign rank_ext  = 32'(rank_full);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= r_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.owner_rank  <= off_any ? '0 : rank_ext[RANK_W-1:0];
            out_reg.local_row   <= FIELD_W'(r_local);
            out_reg.local_col   <= FIELD_W'(c_local);
            out_reg.out_of_grid <= off_any;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // Checks
    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        r_valid == c_valid) else $error("row and column lanes out of step");

    a_off_rank_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_of_grid |-> m_data.owner_rank == '0)
        else $error("off-grid item with nonzero rank");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready) else $error("input stalled without cause");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("output valid after reset");

endmodule
`default_nettype wire

### hdl/mtxown_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`default_nettype none
module mtxown_div #(
    parameter int WN = 32,
    parameter int WD = 32,
    parameter int WS = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [WN-1:0] num,
    input  wire logic [WD-1:0] den,
    input  wire logic [WS-1:0] side_in,
    output logic               out_valid,
    output logic [WN-1:0]      quo,
    output logic [WD-1:0]      rem,
    output logic [WS-1:0]      side_out
);

    logic          vld_reg  [WN];
    logic [WN-1:0] num_reg  [WN];
    logic [WN-1:0] quo_reg  [WN];
    logic [WD-1:0] rem_reg  [WN];
    logic [WD-1:0] den_reg  [WN];
    logic [WS-1:0] side_reg [WN];

    for (genvar k = 0; k < WN; k++) begin : g_stage
        logic          vld_src;
        logic [WN-1:0] num_src;
        logic [WN-1:0] quo_src;
        logic [WD-1:0] rem_src;
        logic [WD-1:0] den_src;
        logic [WS-1:0] side_src;
        logic [WD:0]   trial;
        logic [WD:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign vld_src  = in_valid;
            assign num_src  = num;
            assign quo_src  = '0;
            assign rem_src  = '0;
            assign den_src  = den;
            assign side_src = side_in;
        end else begin : g_next
            assign vld_src  = vld_reg[k-1];
            assign num_src  = num_reg[k-1];
            assign quo_src  = quo_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign den_src  = den_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        // Shift in one dividend bit, subtract when it fits
        assign trial = {rem_src, num_src[WN-1]};
        assign diff  = trial - {1'b0, den_src};
        assign ge    = trial >= {1'b0, den_src};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k]  <= num_src << 1;
                quo_reg[k]  <= {quo_src[WN-2:0], ge};
                rem_reg[k]  <= ge ? diff[WD-1:0] : trial[WD-1:0];
                den_reg[k]  <= den_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = vld_reg[WN-1];
    assign quo       = quo_reg[WN-1];
    assign rem       = rem_reg[WN-1];
    assign side_out  = side_reg[WN-1];

endmodule
`default_nettype wire

### hdl/mtxown_dim.sv
// One dimension: coordinate and local index from a global index.
`default_nettype none
module mtxown_dim #(
    parameter int IW = 32,
    parameter int GB = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [IW-1:0] idx,
    input  wire logic [IW-1:0] chunk,
    input  wire logic [GB:0]   grid,
    input  wire logic          cyclic,
    output logic               out_valid,
    output logic [GB-1:0]      coord,
    output logic [IW-1:0]      local_idx,
    output logic               off
);

    localparam int GW = GB + 1;
    localparam int CW = (IW > GW) ? IW : GW;

    // idx / chunk
    logic          d1_valid;
    logic [IW-1:0] d1_quo;
    logic [IW-1:0] d1_rem;
    logic          d1_cyc;

    mtxown_div #(.WN(IW), .WD(IW), .WS(1)) u_div_chunk (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(in_valid), .num(idx), .den(chunk), .side_in(cyclic),
        .out_valid(d1_valid), .quo(d1_quo), .rem(d1_rem), .side_out(d1_cyc)
    );

    // Plain coordinate beyond the grid
    logic d1_off;
    assign d1_off = !d1_cyc && (CW'(d1_quo) >= CW'(grid));

    // (idx / chunk) / grid, remainder is the cyclic coordinate
    localparam int S2W = IW + GB + 2;
    logic           d2_valid;
    logic [IW-1:0]  d2_quo;
    logic [GW-1:0]  d2_rem;
    logic [S2W-1:0] d2_side;

    mtxown_div #(.WN(IW), .WD(GW), .WS(S2W)) u_div_grid (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d1_valid), .num(d1_quo), .den(grid),
        .side_in({d1_rem, d1_quo[GB-1:0], d1_off, d1_cyc}),
        .out_valid(d2_valid), .quo(d2_quo), .rem(d2_rem), .side_out(d2_side)
    );

    logic [IW-1:0] d2_r;
    logic [GB-1:0] d2_qlow;
    logic          d2_off;
    logic          d2_cyc;
    assign {d2_r, d2_qlow, d2_off, d2_cyc} = d2_side;

    // Multiply stage
    logic          m_vld_reg;
    logic [IW-1:0] m_prod_reg;
    logic [IW-1:0] m_r_reg;
    logic [GB-1:0] m_coord_reg;
    logic          m_off_reg;
    logic          m_cyc_reg;
    logic [2*IW-1:0] prod_full;
    assign prod_full = d2_quo * chunk;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (en) begin
            m_vld_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_prod_reg  <= prod_full[IW-1:0];
            m_r_reg     <= d2_r;
            m_coord_reg <= d2_cyc ? d2_rem[GB-1:0] : d2_qlow;
            m_off_reg   <= d2_off;
            m_cyc_reg   <= d2_cyc;
        end
    end

    // Add stage
    logic          a_vld_reg;
    logic [IW-1:0] a_local_reg;
    logic [GB-1:0] a_coord_reg;
    logic          a_off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_local_reg <= m_cyc_reg ? (m_prod_reg + m_r_reg) : m_r_reg;
            a_coord_reg <= m_coord_reg;
            a_off_reg   <= m_off_reg;
        end
    end

    assign out_valid = a_vld_reg;
    assign coord     = a_coord_reg;
    assign local_idx = a_local_reg;
    assign off       = a_off_reg;

endmodule
`default_nettype wire
